### hw/rtl/lmg_pkg.sv
// Shared types, constants and helpers for the LED matrix glyph renderer.
// No dependencies; every other file of the block but lmg_if refers to this package.
package lmg_pkg;

   // Glyph geometry and store sizes
   localparam int GlyphWidth   = 8;
   localparam int GlyphHeight  = 8;
   localparam int MaxPositions = 8;
   localparam int MaxGlyphs    = 256;
   localparam int FontDepth    = MaxGlyphs * GlyphWidth;
   localparam int FontAddrBits = $clog2(FontDepth);

   // Character codes and mark patterns
   localparam logic [7:0] SpaceCode = 8'h20;
   localparam logic [7:0] ColonCode = 8'h3A;
   localparam logic [7:0] DotCode   = 8'h2E;
   localparam logic [7:0] ColonMark = 8'h66;
   localparam logic [7:0] DotMark   = 8'h60;

   // CSR register indexes (byte address / 4)
   localparam logic [1:0] CsrPositions = 2'd0;
   localparam logic [1:0] CsrLines     = 2'd1;
   localparam logic [1:0] CsrGlyphs    = 2'd2;

   typedef enum logic [1:0] {
      FUNC_PUT_CHAR    = 2'd0,
      FUNC_SET_MARK    = 2'd1,
      FUNC_SET_CURSOR  = 2'd2,
      FUNC_FONT_WRITE  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LOAD,
      ST_RUN
   } seq_state_type;

   typedef struct packed {
      logic [3:0] positions_in_use;
      logic [3:0] lines_in_use;
      logic [8:0] glyph_count;
   } cfg_type;

   // font store port, driven by the sequencer
   typedef struct packed {
      logic                    wr_en;
      logic                    rd_en;
      logic [FontAddrBits-1:0] addr;
      logic [7:0]              wr_data;
   } font_port_type;

   // column shifter control
   typedef struct packed {
      logic       load;
      logic       shift;
      logic       flip;
      logic [7:0] data;
   } shift_ctl_type;

   function automatic logic [7:0] flip8(input logic [7:0] b);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = b[7-i];
      end
      return r;
   endfunction

endpackage

### hw/rtl/lmg_if.sv
// Valid/ready channel interfaces for the glyph renderer request and response.
// Standalone; payload widths are fixed by the block's item format.
interface lmg_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] code;
   logic [2:0] font_column;
   logic [7:0] font_byte;
   logic [2:0] position;
   logic [2:0] line;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, func, code, font_column, font_byte, position, line,
                   red, green, blue, input ready);
   modport sink   (input valid, func, code, font_column, font_byte, position, line,
                   red, green, blue, output ready);
endinterface

interface lmg_rsp_if;
   logic       valid;
   logic       ready;
   logic [8:0] led_index;
   logic [7:0] led_red;
   logic [7:0] led_green;
   logic [7:0] led_blue;
   logic       last_pixel;

   modport source (output valid, led_index, led_red, led_green, led_blue, last_pixel,
                   input ready);
   modport sink   (input valid, led_index, led_red, led_green, led_blue, last_pixel,
                   output ready);
endinterface

### hw/rtl/lmg_font_mem.sv
// Font store: one byte per glyph column, single port, registered read.
// Depends on lmg_pkg for depth and port struct.
module lmg_font_mem (
   input  logic                  clock,
   input  lmg_pkg::font_port_type port,
   output logic [7:0]            rd_data
);

   logic [7:0] mem [lmg_pkg::FontDepth];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (port.wr_en) begin
         mem[port.addr] <= port.wr_data;
      end
      if (port.rd_en) begin
         rd_data_ff <= mem[port.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/lmg_col_shifter.sv
// Column serializer: holds one glyph column and hands out one pixel bit a cycle while shift is set.
// Depends on lmg_pkg (shift control struct, bit reversal).
module lmg_col_shifter (
   input  logic                  clock,
   input  lmg_pkg::shift_ctl_type ctl,
   output logic                  pixel
);

   logic [7:0] sr_ff;
   logic [7:0] sr_in;

   always_comb begin
      sr_in = sr_ff;
      if (ctl.load) begin
         // odd columns run the other way along the strip
         sr_in = ctl.flip ? lmg_pkg::flip8(ctl.data) : ctl.data;
      end else if (ctl.shift) begin
         sr_in = {1'b0, sr_ff[7:1]};
      end
   end

   always_ff @(posedge clock) begin
      sr_ff <= sr_in;
   end

   assign pixel = sr_ff[0];

endmodule

### hw/rtl/lmg_seq.sv
// Sequencer: takes request items, keeps cursor and mark state, walks the
// glyph column by column and fills the response register. Uses lmg_pkg, lmg_if.
module lmg_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  lmg_pkg::cfg_type       cfg,
   lmg_req_if.sink                req,
   lmg_rsp_if.source              rsp,
   output lmg_pkg::font_port_type font_port,
   input  logic [7:0]             font_data,
   output lmg_pkg::shift_ctl_type shift_ctl,
   input  logic                   pixel
);

   lmg_pkg::seq_state_type state_ff, state_in;

   logic [7:0]  code_ff;
   logic [7:0]  red_ff, green_ff, blue_ff;
   logic [7:0]  mark_bits_ff   [lmg_pkg::MaxPositions];
   logic [23:0] mark_colour_ff [lmg_pkg::MaxPositions];
   logic [2:0]  cur_pos_ff, cur_line_ff;
   logic [2:0]  col_ff, col_in;
   logic [2:0]  bit_ff, bit_in;
   logic        use_mark_ff, use_mark_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [8:0]  idx_ff;
   logic [7:0]  led_r_ff, led_g_ff, led_b_ff;
   logic        last_ff;

   logic        accept;
   logic        advance;
   logic        emit;
   logic        col_end;
   logic        char_end;
   logic [2:0]  next_col;
   logic [7:0]  cur_mark;
   logic [23:0] cur_mcol;
   logic        next_is_mark;
   logic [3:0]  np, nl;
   logic [7:0]  new_mark;
   lmg_pkg::func_type func;

   assign func     = lmg_pkg::func_type'(req.func);
   assign accept   = req.valid && req.ready;
   assign advance  = !rsp_valid_ff || rsp.ready;
   assign emit     = (state_ff == lmg_pkg::ST_RUN) && advance;
   assign col_end  = emit && (bit_ff == 3'(lmg_pkg::GlyphHeight - 1));
   assign char_end = col_end && (col_ff == 3'(lmg_pkg::GlyphWidth - 1));
   assign cur_mark = mark_bits_ff[cur_pos_ff];
   assign cur_mcol = mark_colour_ff[cur_pos_ff];
   assign next_col = (state_ff == lmg_pkg::ST_RUN) ? col_ff + 3'd1 : 3'd0;
   assign next_is_mark = (next_col == 3'(lmg_pkg::GlyphWidth - 1)) && (cur_mark != 8'd0);
   assign new_mark = (req.code == lmg_pkg::ColonCode) ? lmg_pkg::ColonMark :
                     (req.code == lmg_pkg::DotCode)   ? lmg_pkg::DotMark : 8'd0;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lmg_pkg::ST_IDLE: begin
            if (accept && func == lmg_pkg::FUNC_PUT_CHAR) state_in = lmg_pkg::ST_FETCH;
         end
         lmg_pkg::ST_FETCH: state_in = lmg_pkg::ST_LOAD;
         lmg_pkg::ST_LOAD:  state_in = lmg_pkg::ST_RUN;
         lmg_pkg::ST_RUN: begin
            if (char_end) state_in = lmg_pkg::ST_IDLE;
         end
         default: state_in = lmg_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req.ready         = (state_ff == lmg_pkg::ST_IDLE);
      font_port.wr_en   = accept && (func == lmg_pkg::FUNC_FONT_WRITE);
      font_port.wr_data = req.font_byte;
      // prefetch the following column while the current one shifts out
      font_port.rd_en   = (state_ff == lmg_pkg::ST_FETCH) ||
                          (emit && bit_ff == 3'd0 &&
                           col_ff != 3'(lmg_pkg::GlyphWidth - 1));
      if (font_port.wr_en) begin
         font_port.addr = {req.code, req.font_column};
      end else if (state_ff == lmg_pkg::ST_FETCH) begin
         font_port.addr = {code_ff, 3'd0};
      end else begin
         font_port.addr = {code_ff, col_ff + 3'd1};
      end
      shift_ctl.load  = (state_ff == lmg_pkg::ST_LOAD) || (col_end && !char_end);
      shift_ctl.shift = emit;
      shift_ctl.flip  = next_col[0];
      shift_ctl.data  = next_is_mark ? cur_mark : font_data;
   end

   always_comb begin
      col_in      = col_ff;
      bit_in      = bit_ff;
      use_mark_in = use_mark_ff;
      if (state_ff == lmg_pkg::ST_LOAD) begin
         col_in      = 3'd0;
         bit_in      = 3'd0;
         use_mark_in = next_is_mark;
      end else if (emit) begin
         bit_in = bit_ff + 3'd1;
         if (col_end) begin
            bit_in      = 3'd0;
            col_in      = col_ff + 3'd1;
            use_mark_in = next_is_mark;
         end
      end
      rsp_valid_in = emit ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
      np = {1'b0, cur_pos_ff} + 4'd1;
      nl = {1'b0, cur_line_ff} + 4'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lmg_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cur_pos_ff   <= 3'd0;
         cur_line_ff  <= 3'd0;
         col_ff       <= 3'd0;
         bit_ff       <= 3'd0;
         use_mark_ff  <= 1'b0;
         for (int i = 0; i < lmg_pkg::MaxPositions; i++) begin
            mark_bits_ff[i]   <= 8'd0;
            mark_colour_ff[i] <= 24'd0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         col_ff       <= col_in;
         bit_ff       <= bit_in;
         use_mark_ff  <= use_mark_in;
         if (accept && func == lmg_pkg::FUNC_SET_MARK &&
             {1'b0, req.position} < cfg.positions_in_use) begin
            mark_bits_ff[req.position]   <= new_mark;
            mark_colour_ff[req.position] <= {req.red, req.green, req.blue};
         end
         if (accept && func == lmg_pkg::FUNC_SET_CURSOR &&
             {1'b0, req.position} < cfg.positions_in_use &&
             {1'b0, req.line} < cfg.lines_in_use) begin
            cur_pos_ff  <= req.position;
            cur_line_ff <= req.line;
         end
         if (char_end) begin
            if (np >= cfg.positions_in_use || np >= 4'(lmg_pkg::MaxPositions)) begin
               cur_pos_ff <= 3'd0;
               if (nl >= cfg.lines_in_use || nl > 4'd7) begin
                  cur_line_ff <= 3'd0;
               end else begin
                  cur_line_ff <= nl[2:0];
               end
            end else begin
               cur_pos_ff <= np[2:0];
            end
         end
      end
   end

   // item and response payload
   always_ff @(posedge clock) begin
      if (accept && func == lmg_pkg::FUNC_PUT_CHAR) begin
         code_ff  <= ({1'b0, req.code} >= cfg.glyph_count) ? lmg_pkg::SpaceCode : req.code;
         red_ff   <= req.red;
         green_ff <= req.green;
         blue_ff  <= req.blue;
      end
      if (emit) begin
         idx_ff   <= {cur_pos_ff, col_ff, bit_ff};
         last_ff  <= (col_ff == 3'(lmg_pkg::GlyphWidth - 1)) &&
                     (bit_ff == 3'(lmg_pkg::GlyphHeight - 1));
         led_r_ff <= !pixel ? 8'd0 : (use_mark_ff ? cur_mcol[23:16] : red_ff);
         led_g_ff <= !pixel ? 8'd0 : (use_mark_ff ? cur_mcol[15:8]  : green_ff);
         led_b_ff <= !pixel ? 8'd0 : (use_mark_ff ? cur_mcol[7:0]   : blue_ff);
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.led_index  = idx_ff;
   assign rsp.led_red    = led_r_ff;
   assign rsp.led_green  = led_g_ff;
   assign rsp.led_blue   = led_b_ff;
   assign rsp.last_pixel = last_ff;

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && last_ff |-> idx_ff[5:0] == 6'h3F)
      else $error("last pixel flagged off the final index");

   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      char_end |=> state_ff == lmg_pkg::ST_IDLE)
      else $error("sequencer not idle after final pixel");

   a_port_excl: assert property (@(posedge clock) disable iff (reset)
      !(font_port.wr_en && font_port.rd_en))
      else $error("font store read and write in one cycle");

   a_cursor_src: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(cur_pos_ff) |->
         $past(char_end) || $past(accept && func == lmg_pkg::FUNC_SET_CURSOR))
      else $error("cursor moved without a character or set cursor");

endmodule

### hw/rtl/led_matrix_glyph_renderer_top.sv
// Top level of the LED matrix glyph renderer: CSR block and datapath wiring.
// Depends on lmg_pkg, lmg_if, lmg_font_mem, lmg_col_shifter and lmg_seq.
//
// Usage
//  - req_chan (valid/ready) takes one item per transfer: put character,
//    set colon/dot mark, set cursor, or write one font column.
//  - rsp_chan (valid/ready) carries one LED write per transfer: index, colour
//    and last_pixel, which flags the final write of a character.
//  - CSR port (APB style, pready tied high): positions_in_use at 0x0,
//    lines_in_use at 0x4, glyph_count at 0x8. Write them only while idle.
// Timing
//  - Mark, cursor and font items produce no transfer.
//  - A put character item gives 64 LED writes, one per cycle from the column
//    shifter while rsp_chan is not stalled (next column prefetched while the
//    current one shifts). The request passes the FETCH and LOAD states, and
//    the first write is registered from the RUN state.
//  - A stall on rsp_chan freezes the shifter; nothing is dropped. The next
//    request is taken as soon as the last write sits in the output register.
// Reset
//  - Synchronous, active high: cursor to 0/0, marks cleared, CSRs to 8, 1,
//    256. The font store is not cleared; load glyphs before using them.
module led_matrix_glyph_renderer_top (
   input  logic        clock,
   input  logic        reset,
   lmg_req_if.sink     req_chan,
   lmg_rsp_if.source   rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   lmg_pkg::cfg_type       cfg_ff;
   lmg_pkg::font_port_type font_port;
   lmg_pkg::shift_ctl_type shift_ctl;
   logic [7:0]             font_data;
   logic                   pixel;
   logic                   csr_wr;
   logic [1:0]             csr_idx;

   // ---- CSR block: writes land at the access phase edge ----
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.positions_in_use <= 4'd8;
         cfg_ff.lines_in_use     <= 4'd1;
         cfg_ff.glyph_count      <= 9'd256;
      end else if (csr_wr) begin
         // writes to the unused slot are dropped
         unique case (csr_idx)
            lmg_pkg::CsrPositions: cfg_ff.positions_in_use <= csr_pwdata[3:0];
            lmg_pkg::CsrLines:     cfg_ff.lines_in_use     <= csr_pwdata[3:0];
            lmg_pkg::CsrGlyphs:    cfg_ff.glyph_count      <= csr_pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         lmg_pkg::CsrPositions: csr_prdata = {28'd0, cfg_ff.positions_in_use};
         lmg_pkg::CsrLines:     csr_prdata = {28'd0, cfg_ff.lines_in_use};
         lmg_pkg::CsrGlyphs:    csr_prdata = {23'd0, cfg_ff.glyph_count};
         default:               csr_prdata = 32'd0;
      endcase
   end

   // ---- datapath ----
   // font store: 2048 bytes, one access a cycle, read data registered
   lmg_font_mem u_font_mem (
      .clock   (clock),
      .port    (font_port),
      .rd_data (font_data)
   );

   // column serializer: one pixel bit per cycle while the sequencer shifts
   lmg_col_shifter u_shifter (
      .clock (clock),
      .ctl   (shift_ctl),
      .pixel (pixel)
   );

   // control, cursor/mark state and output register
   lmg_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .font_port (font_port),
      .font_data (font_data),
      .shift_ctl (shift_ctl),
      .pixel     (pixel)
   );

endmodule

### dv/tb_led_matrix_glyph_renderer_top.sv
// Self-checking testbench for led_matrix_glyph_renderer_top. Directed and random
// character, mark, cursor and font items are checked against a local pixel predictor.
// Depends on lmg_pkg, lmg_if and the renderer RTL.
`timescale 1ns / 1ps

module tb_led_matrix_glyph_renderer_top;

   localparam int MaxReports   = 10;
   localparam int HoldCycles   = 600;      // long receiver hold-off
   localparam int SettleCycles = 8;        // quiet time before a CSR write
   localparam int DrainCycles  = 100;      // quiet time at the end
   localparam int RunLimitNs   = 100000000;
   localparam int LedsPerChar  = lmg_pkg::GlyphWidth * lmg_pkg::GlyphHeight;

   typedef struct packed {
      lmg_pkg::func_type func;
      logic [7:0] code;
      logic [2:0] font_column;
      logic [7:0] font_byte;
      logic [2:0] position;
      logic [2:0] line;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } char_item_type;

   typedef struct packed {
      logic [8:0] index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } led_write_type;

   // clock, reset, CSR port
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   lmg_req_if req_chan ();
   lmg_rsp_if rsp_chan ();

   // request payload is one register, fanned out to the channel
   char_item_type req_item  = '0;
   logic          req_valid = 1'b0;
   logic          rsp_ready = 1'b0;

   assign req_chan.valid       = req_valid;
   assign req_chan.func        = req_item.func;
   assign req_chan.code        = req_item.code;
   assign req_chan.font_column = req_item.font_column;
   assign req_chan.font_byte   = req_item.font_byte;
   assign req_chan.position    = req_item.position;
   assign req_chan.line        = req_item.line;
   assign req_chan.red         = req_item.red;
   assign req_chan.green       = req_item.green;
   assign req_chan.blue        = req_item.blue;
   assign rsp_chan.ready       = rsp_ready;

   led_matrix_glyph_renderer_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Shadow of the renderer state, advanced at each request transfer
   // ---------------------------------------------------------------------------
   logic [7:0]  font_shadow [0:lmg_pkg::FontDepth-1];
   logic [7:0]  mark_shadow [0:lmg_pkg::MaxPositions-1];
   logic [23:0] mark_rgb    [0:lmg_pkg::MaxPositions-1];
   int          cur_pos       = 0;
   int          cur_line      = 0;
   int          cfg_positions = 8;
   int          cfg_lines     = 1;
   int          cfg_glyphs    = 256;

   led_write_type leds_due [$];     // LED writes still to arrive, oldest first
   int            errors = 0;

   // Stimulus bookkeeping: which font columns have been written so far, so
   // a character is only rendered once its whole glyph is loaded.
   char_item_type items_pending [$];
   logic [7:0]    glyph_cols_loaded [0:lmg_pkg::MaxGlyphs-1];
   logic [7:0]    loaded_glyphs [$];

   // handshake bookkeeping and idling control
   int   req_offers  = 0;
   int   req_accepts = 0;
   int   req_gap     = 0;
   int   rsp_stall   = 0;
   bit   req_idle_on = 1'b1;
   bit   rsp_idle_on = 1'b1;
   bit   hold_start  = 1'b0;
   bit   hold_rsp    = 1'b0;

   task automatic flag_error(input string msg);
      errors++;
      if (errors <= MaxReports) $display("%s", msg);
   endtask

   // Applies one item to the shadow state; a character queues its 64 LED writes.
   task automatic render_item(input char_item_type it);
      logic [7:0]    glyph;
      logic [7:0]    bits;
      logic [7:0]    flipped;
      logic [7:0]    mbits;
      logic [23:0]   rgb;
      led_write_type w;
      int            cp;
      int            k;
      int            np;
      case (it.func)
         lmg_pkg::FUNC_SET_MARK: begin
            if (it.position < cfg_positions) begin
               mark_shadow[it.position] =
                  (it.code == lmg_pkg::ColonCode) ? lmg_pkg::ColonMark :
                  (it.code == lmg_pkg::DotCode)   ? lmg_pkg::DotMark : 8'h00;
               mark_rgb[it.position] = {it.red, it.green, it.blue};
            end
         end
         lmg_pkg::FUNC_SET_CURSOR: begin
            if (it.position < cfg_positions && it.line < cfg_lines) begin
               cur_pos  = it.position;
               cur_line = it.line;
            end
         end
         lmg_pkg::FUNC_FONT_WRITE: begin
            font_shadow[it.code * lmg_pkg::GlyphWidth + it.font_column] = it.font_byte;
         end
         lmg_pkg::FUNC_PUT_CHAR: begin
            // codes past the glyph count render as a space
            glyph = (it.code >= cfg_glyphs) ? lmg_pkg::SpaceCode : it.code;
            cp    = cur_pos;
            mbits = mark_shadow[cp];
            k     = 0;
            for (int c = 0; c < lmg_pkg::GlyphWidth; c++) begin
               bits = font_shadow[glyph * lmg_pkg::GlyphWidth + c];
               rgb  = {it.red, it.green, it.blue};
               // last column shows the colon/dot mark in its own colour
               if (c == lmg_pkg::GlyphWidth - 1 && mbits != 8'h00) begin
                  bits = mbits;
                  rgb  = mark_rgb[cp];
               end
               // serpentine wiring: odd columns run bottom-up
               if (c % 2 == 1) begin
                  for (int i = 0; i < 8; i++) flipped[i] = bits[7-i];
                  bits = flipped;
               end
               for (int h = 0; h < lmg_pkg::GlyphHeight; h++) begin
                  w.index = 9'(LedsPerChar * cp + k);
                  {w.red, w.green, w.blue} = bits[h] ? rgb : 24'h0;
                  w.last = (k == LedsPerChar - 1);
                  leds_due.push_back(w);
                  k++;
               end
            end
            // cursor advance, wrapping position then line
            np = cp + 1;
            if (np >= cfg_positions || np >= lmg_pkg::MaxPositions) begin
               np       = 0;
               cur_line = (cur_line + 1 >= cfg_lines || cur_line + 1 > 7) ? 0 : cur_line + 1;
            end
            cur_pos = np;
         end
      endcase
   endtask

   // Mostly back-to-back, sometimes short gaps, rarely long ones.
   function automatic int draw_gap(input bit idle_on);
      int roll;
      roll = $urandom_range(0, 99);
      if (!idle_on || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // ---------------------------------------------------------------------------
   // Request driver: changes at the falling edge, fed from items_pending
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepts == req_offers) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap--;
         end else if (items_pending.size() != 0) begin
            req_item  <= items_pending.pop_front();
            req_valid <= 1'b1;
            req_offers++;
            req_gap = draw_gap(req_idle_on);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // request transfer: advance the predictor
   always @(posedge clock) begin
      if (!reset && req_valid && req_chan.ready) begin
         render_item(req_item);
         req_accepts++;
      end
   end

   // ---------------------------------------------------------------------------
   // Response side: random ready with an occasional long hold-off
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset || hold_rsp) begin
         rsp_ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_ready <= 1'b1;
         rsp_stall = draw_gap(rsp_idle_on);
      end
   end

   // hold-off counted here so the sender keeps offering and the block backs up
   initial begin
      wait (hold_start);
      @(posedge clock);
      hold_rsp = 1'b1;
      repeat (HoldCycles) @(posedge clock);
      hold_rsp = 1'b0;
   end

   // response transfer: compare against the oldest expected LED write
   always @(posedge clock) begin : led_monitor
      led_write_type got;
      led_write_type want;
      if (!reset && rsp_chan.valid && rsp_ready) begin
         got = {rsp_chan.led_index, rsp_chan.led_red, rsp_chan.led_green,
                rsp_chan.led_blue, rsp_chan.last_pixel};
         if (leds_due.size() == 0) begin
            flag_error($sformatf("LED write with none expected: idx %0d rgb %h/%h/%h last %0b",
                                 got.index, got.red, got.green, got.blue, got.last));
         end else begin
            want = leds_due.pop_front();
            if (got !== want) begin
               flag_error($sformatf({"LED write mismatch: want idx %0d rgb %h/%h/%h last %0b,",
                                     " got idx %0d rgb %h/%h/%h last %0b"},
                                    want.index, want.red, want.green, want.blue, want.last,
                                    got.index, got.red, got.green, got.blue, got.last));
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   function automatic char_item_type random_item();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[$bits(char_item_type)-1:0];
   endfunction

   function automatic char_item_type make_item(
         input lmg_pkg::func_type f, input logic [7:0] code,
         input logic [2:0] pos, input logic [2:0] line,
         input logic [23:0] rgb);
      char_item_type it;
      it          = '0;
      it.func     = f;
      it.code     = code;
      it.position = pos;
      it.line     = line;
      {it.red, it.green, it.blue} = rgb;
      return it;
   endfunction

   task automatic queue_item(input char_item_type it);
      if (it.func == lmg_pkg::FUNC_FONT_WRITE && glyph_cols_loaded[it.code] != 8'hFF) begin
         glyph_cols_loaded[it.code][it.font_column] = 1'b1;
         if (glyph_cols_loaded[it.code] == 8'hFF) loaded_glyphs.push_back(it.code);
      end
      items_pending.push_back(it);
   endtask

   // all columns of one glyph; fill < 0 gives random bytes
   task automatic queue_glyph(input logic [7:0] code, input int fill);
      char_item_type it;
      it = make_item(lmg_pkg::FUNC_FONT_WRITE, code, 3'd0, 3'd0, 24'h0);
      for (int c = 0; c < lmg_pkg::GlyphWidth; c++) begin
         it.font_column = 3'(c);
         it.font_byte   = (fill < 0) ? 8'($urandom) : 8'(fill);
         queue_item(it);
      end
   endtask

   // A character whose glyph is not fully loaded either gets it loaded first
   // or is swapped for one that is: unwritten font entries are never read.
   task automatic queue_put(input char_item_type it);
      logic [7:0] glyph;
      it.func = lmg_pkg::FUNC_PUT_CHAR;
      glyph   = (it.code >= cfg_glyphs) ? lmg_pkg::SpaceCode : it.code;
      if (glyph_cols_loaded[glyph] != 8'hFF) begin
         if ($urandom_range(0, 3) == 0) queue_glyph(glyph, -1);
         else it.code = loaded_glyphs[$urandom_range(0, loaded_glyphs.size() - 1)];
      end
      queue_item(it);
   endtask

   task automatic queue_random(input int count);
      char_item_type it;
      int            roll;
      repeat (count) begin
         it   = random_item();
         roll = $urandom_range(0, 99);
         if (roll < 45) begin
            queue_put(it);
         end else if (roll < 60) begin
            it.func = lmg_pkg::FUNC_SET_MARK;
            case ($urandom_range(0, 2))
               0:       it.code = lmg_pkg::ColonCode;
               1:       it.code = lmg_pkg::DotCode;
               default: ;
            endcase
            queue_item(it);
         end else if (roll < 75) begin
            it.func = lmg_pkg::FUNC_SET_CURSOR;
            queue_item(it);
         end else begin
            it.func = lmg_pkg::FUNC_FONT_WRITE;
            // half the time rework a glyph already in use
            if ($urandom_range(0, 1) == 0)
               it.code = loaded_glyphs[$urandom_range(0, loaded_glyphs.size() - 1)];
            queue_item(it);
         end
      end
   endtask

   // waits until every item is sent and every expected LED write is in
   task automatic wait_drained(input int settle);
      while (items_pending.size() != 0 || req_valid || leds_due.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // APB write, then read back the same register
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] readback;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== value)
         flag_error($sformatf("CSR %0d readback: want %h, got %h", idx, value, readback));
   endtask

   task automatic set_config(input int positions, input int lines, input int glyphs);
      csr_write(lmg_pkg::CsrPositions, positions);
      csr_write(lmg_pkg::CsrLines, lines);
      csr_write(lmg_pkg::CsrGlyphs, glyphs);
      cfg_positions = positions;
      cfg_lines     = lines;
      cfg_glyphs    = glyphs;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------
   initial begin
      for (int i = 0; i < lmg_pkg::MaxPositions; i++) begin
         mark_shadow[i] = 8'h00;
         mark_rgb[i]    = 24'h0;
      end
      for (int i = 0; i < lmg_pkg::MaxGlyphs; i++) glyph_cols_loaded[i] = 8'h00;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset config (8 positions, 1 line, 256 glyphs); space, blank, solid glyphs
      queue_glyph(lmg_pkg::SpaceCode, -1);
      queue_glyph(8'h00, 8'h00);
      queue_glyph(8'hFF, 8'hFF);
      queue_put(make_item(lmg_pkg::FUNC_PUT_CHAR, lmg_pkg::SpaceCode, 3'd0, 3'd0, 24'hFF00FF));
      queue_put(make_item(lmg_pkg::FUNC_PUT_CHAR, 8'h00, 3'd0, 3'd0, 24'hFFFFFF));
      queue_put(make_item(lmg_pkg::FUNC_PUT_CHAR, 8'hFF, 3'd0, 3'd0, 24'h00FF00));
      // colon, dot, and a mark cleared by another code
      queue_item(make_item(lmg_pkg::FUNC_SET_MARK, lmg_pkg::ColonCode, 3'd0, 3'd0, 24'h123456));
      queue_item(make_item(lmg_pkg::FUNC_SET_MARK, lmg_pkg::DotCode, 3'd1, 3'd0, 24'hFFFFFF));
      queue_item(make_item(lmg_pkg::FUNC_SET_MARK, lmg_pkg::ColonCode, 3'd2, 3'd0, 24'h00FF00));
      queue_item(make_item(lmg_pkg::FUNC_SET_MARK, 8'h41, 3'd2, 3'd0, 24'hABCDEF));
      queue_item(make_item(lmg_pkg::FUNC_SET_CURSOR, 8'h00, 3'd0, 3'd0, 24'h0));
      queue_put(make_item(lmg_pkg::FUNC_PUT_CHAR, 8'hFF, 3'd0, 3'd0, 24'h0000FF));
      queue_put(make_item(lmg_pkg::FUNC_PUT_CHAR, lmg_pkg::SpaceCode, 3'd0, 3'd0, 24'h808080));
      queue_put(make_item(lmg_pkg::FUNC_PUT_CHAR, 8'hFF, 3'd0, 3'd0, 24'h7F7F7F));
      // last position: top LED indexes, then wrap to position 0
      queue_item(make_item(lmg_pkg::FUNC_SET_MARK, lmg_pkg::ColonCode, 3'd7, 3'd0, 24'h00FF00));
      queue_item(make_item(lmg_pkg::FUNC_SET_CURSOR, 8'h00, 3'd7, 3'd0, 24'h0));
      queue_put(make_item(lmg_pkg::FUNC_PUT_CHAR, 8'h00, 3'd0, 3'd0, 24'hFFFFFF));
      // cursor line out of range is ignored
      queue_item(make_item(lmg_pkg::FUNC_SET_CURSOR, 8'h00, 3'd3, 3'd1, 24'h0));
      queue_put(make_item(lmg_pkg::FUNC_PUT_CHAR, lmg_pkg::SpaceCode, 3'd0, 3'd0, 24'h010203));
      queue_random(20);
      wait_drained(SettleCycles);

      // one position, one line, one glyph: every other code is a space
      set_config(1, 1, 1);
      queue_item(make_item(lmg_pkg::FUNC_SET_MARK, lmg_pkg::ColonCode, 3'd1, 3'd0, 24'hFFFFFF));
      queue_item(make_item(lmg_pkg::FUNC_SET_CURSOR, 8'h00, 3'd1, 3'd0, 24'h0));
      queue_put(make_item(lmg_pkg::FUNC_PUT_CHAR, 8'hFF, 3'd0, 3'd0, 24'hFFFFFF));
      queue_put(make_item(lmg_pkg::FUNC_PUT_CHAR, 8'h00, 3'd0, 3'd0, 24'hFFFFFF));
      queue_put(make_item(lmg_pkg::FUNC_PUT_CHAR, 8'h7F, 3'd0, 3'd0, 24'hC0FFEE));
      queue_random(15);
      wait_drained(SettleCycles);

      // full display: wrap at the last line, then a long receiver hold-off
      set_config(8, 8, 256);
      queue_item(make_item(lmg_pkg::FUNC_SET_CURSOR, 8'h00, 3'd7, 3'd7, 24'h0));
      queue_put(make_item(lmg_pkg::FUNC_PUT_CHAR, 8'hFF, 3'd0, 3'd0, 24'hFFFFFF));
      queue_put(make_item(lmg_pkg::FUNC_PUT_CHAR, 8'h00, 3'd0, 3'd0, 24'hFFFFFF));
      hold_start = 1'b1;
      repeat (8) queue_put(random_item());
      wait_drained(SettleCycles);
      queue_random(25);
      wait_drained(SettleCycles);

      // mid-range settings, both sides back to back
      set_config(5, 3, 48);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      queue_random(30);
      wait_drained(SettleCycles);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;

      set_config($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 256));
      queue_random(30);
      wait_drained(DrainCycles);

      if (leds_due.size() != 0)
         flag_error($sformatf("%0d LED writes never arrived", leds_due.size()));
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #(RunLimitNs);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
